### hdl/bblc_pkg.sv
// ----------------------------------------------------------------------------
// bblc_pkg: shared types and constants of the byte-budget LRU cache unit
// Field widths, request/response structs, status codes and cell control.
// ----------------------------------------------------------------------------
package bblc_pkg;

    localparam int KEY_BITS     = 32;
    localparam int SIZE_BITS    = 24;
    localparam int USED_BITS    = 32;
    localparam int EVICT_BITS   = 5;
    localparam int ENTRIES_DFLT = 16;
    localparam logic [31:0] BUDGET_RESET = 32'd65536;

    typedef enum logic [1:0] {
        ST_HIT     = 2'd0,
        ST_STORED  = 2'd1,
        ST_PASSED  = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic                 present;
        logic [SIZE_BITS-1:0] obj_size;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [EVICT_BITS-1:0] evicted_count;
        logic [USED_BITS-1:0]  bytes_used;
    } rsp_t;

    // Per-cell control: take the left neighbor's entry, or drop the own entry.
    typedef struct packed {
        logic shift;
        logic clr;
    } cell_ctl_t;

endpackage

### hdl/bblc_cell.sv
// ----------------------------------------------------------------------------
// bblc_cell: one slot of the recency-ordered entry chain
// Holds key, size and valid; shifts in the left neighbor's entry on request.
// ----------------------------------------------------------------------------
module bblc_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bblc_pkg::cell_ctl_t            ctl,
    input  logic [bblc_pkg::KEY_BITS-1:0]  left_key,
    input  logic [bblc_pkg::SIZE_BITS-1:0] left_size,
    input  logic                           left_valid,
    input  logic [bblc_pkg::KEY_BITS-1:0]  lookup_key,
    output logic [bblc_pkg::KEY_BITS-1:0]  key,
    output logic [bblc_pkg::SIZE_BITS-1:0] size,
    output logic                           valid,
    output logic                           match
);

    logic [bblc_pkg::KEY_BITS-1:0]  key_reg;
    logic [bblc_pkg::SIZE_BITS-1:0] size_reg;
    logic                           valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_reg <= left_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift && !ctl.clr)
        begin
            key_reg  <= left_key;
            size_reg <= left_size;
        end
    end

    assign key   = key_reg;
    assign size  = size_reg;
    assign valid = valid_reg;
    assign match = valid_reg && (key_reg == lookup_key);

endmodule

### hdl/byte_budget_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_unit: size-aware LRU cache directory
// Entries live in a chain of cells ordered most recent (cell 0) to least.
//
//   Channel   Signals                         Handshake
//   request   start, busy, req                taken when start && !busy
//   response  done, rsp                       one-cycle strobe, no stall
//   config    cfg_valid, cfg_ready, cfg_data  written when valid && ready
//
// A hit or an absent object is answered from the lookup state. A stored miss
// passes through lookup, eviction and insert; a miss that does not fit is
// passed through from the eviction state. The eviction walk drops one tail
// cell a cycle, and goes to insert directly when the dropped cell only frees
// a slot in a full table. Reset empties the table and sets the budget to 65536.
// The response cannot be stalled; a new request may start in the done cycle.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_unit #(
    parameter int ENTRIES = bblc_pkg::ENTRIES_DFLT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bblc_pkg::req_t       req,
    output logic                 done,
    output bblc_pkg::rsp_t       rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS = $clog2(ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_EVICT  = 4'b0100,
        S_INSERT = 4'b1000
    } state_t;

    state_t                              state_reg, state_next;
    bblc_pkg::req_t                      req_reg;
    logic [31:0]                         budget_reg;
    logic [bblc_pkg::USED_BITS-1:0]      used_reg, used_next;
    logic [CNT_BITS-1:0]                 count_reg, count_next;
    logic [bblc_pkg::EVICT_BITS-1:0]     evict_reg, evict_next;
    logic                                done_reg, done_next;
    bblc_pkg::rsp_t                      rsp_reg, rsp_next;

    bblc_pkg::cell_ctl_t                 ctl [ENTRIES];
    logic [bblc_pkg::KEY_BITS-1:0]       c_key [ENTRIES];
    logic [bblc_pkg::SIZE_BITS-1:0]      c_size [ENTRIES];
    logic [ENTRIES-1:0]                  c_valid;
    logic [ENTRIES-1:0]                  c_match;

    logic [bblc_pkg::KEY_BITS-1:0]       head_key;
    logic [bblc_pkg::SIZE_BITS-1:0]      head_size;
    logic [bblc_pkg::KEY_BITS-1:0]       hit_key;
    logic [bblc_pkg::SIZE_BITS-1:0]      hit_size;
    logic [bblc_pkg::SIZE_BITS-1:0]      tail_size;
    logic [IDX_BITS-1:0]                 tail_idx;
    logic [CNT_BITS-1:0]                 tail_cnt;
    logic                                hit;
    logic                                over;
    logic                                do_hit, do_insert, do_evict;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                bblc_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .ctl(ctl[g]),
                    .left_key(head_key), .left_size(head_size), .left_valid(1'b1),
                    .lookup_key(req_reg.key),
                    .key(c_key[g]), .size(c_size[g]), .valid(c_valid[g]),
                    .match(c_match[g])
                );
            end
            else
            begin : g_body
                bblc_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .ctl(ctl[g]),
                    .left_key(c_key[g-1]), .left_size(c_size[g-1]),
                    .left_valid(c_valid[g-1]),
                    .lookup_key(req_reg.key),
                    .key(c_key[g]), .size(c_size[g]), .valid(c_valid[g]),
                    .match(c_match[g])
                );
            end
        end
    endgenerate

    assign hit      = |c_match;
    assign tail_cnt = count_reg - CNT_BITS'(1);
    assign tail_idx = tail_cnt[IDX_BITS-1:0];
    assign over     = ({1'b0, used_reg} + 33'(req_reg.obj_size)) > {1'b0, budget_reg};

    always_comb
    begin
        hit_key   = '0;
        hit_size  = '0;
        tail_size = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (c_match[i])
            begin
                hit_key  = hit_key | c_key[i];
                hit_size = hit_size | c_size[i];
            end
            if (IDX_BITS'(i) == tail_idx)
            begin
                tail_size = c_size[i];
            end
        end
    end

    assign do_hit    = (state_reg == S_LOOKUP) && hit;
    assign do_insert = (state_reg == S_INSERT);
    assign do_evict  = (state_reg == S_EVICT) && (count_reg != '0) &&
                       (over || (count_reg == CNT_BITS'(ENTRIES)));

    assign head_key  = do_hit ? hit_key : req_reg.key;
    assign head_size = do_hit ? hit_size : req_reg.obj_size;

    // On a hit, cells up to and including the hit slot shift one place back.
    always_comb
    begin
        logic below;
        below = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            below       = below | c_match[i];
            ctl[i].shift = do_insert || (do_hit && below);
            ctl[i].clr   = do_evict && (IDX_BITS'(i) == tail_idx);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        count_next = count_reg;
        evict_next = evict_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                evict_next = '0;
                if (start)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (hit || !req_reg.present)
                begin
                    state_next        = S_IDLE;
                    done_next         = 1'b1;
                    rsp_next.status   = hit ? bblc_pkg::ST_HIT : bblc_pkg::ST_ABSENT;
                    rsp_next.evicted_count = '0;
                    rsp_next.bytes_used    = used_reg;
                end
                else
                begin
                    state_next = S_EVICT;
                end
            end
            S_EVICT:
            begin
                if (do_evict)
                begin
                    used_next  = used_reg - 32'(tail_size);
                    count_next = tail_cnt;
                    evict_next = evict_reg + (bblc_pkg::EVICT_BITS)'(1);
                    // Room freed for a full table: insert next cycle.
                    if (!over)
                    begin
                        state_next = S_INSERT;
                    end
                end
                else if (over)
                begin
                    state_next             = S_IDLE;
                    done_next              = 1'b1;
                    rsp_next.status        = bblc_pkg::ST_PASSED;
                    rsp_next.evicted_count = evict_reg;
                    rsp_next.bytes_used    = used_reg;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                state_next             = S_IDLE;
                used_next              = used_reg + 32'(req_reg.obj_size);
                count_next             = count_reg + CNT_BITS'(1);
                done_next              = 1'b1;
                rsp_next.status        = bblc_pkg::ST_STORED;
                rsp_next.evicted_count = evict_reg;
                rsp_next.bytes_used    = used_reg + 32'(req_reg.obj_size);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            count_reg  <= '0;
            evict_reg  <= '0;
            done_reg   <= 1'b0;
            budget_reg <= bblc_pkg::BUDGET_RESET;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            count_reg <= count_next;
            evict_reg <= evict_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                budget_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (start && !busy)
        begin
            req_reg <= req;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    assign cfg_ready = 1'b1;

    // The chain stays packed: valid cells form a run starting at cell 0.
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (c_valid & (c_valid + ENTRIES'(1))) == '0)
        else $error("valid cells are not contiguous from the head");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(c_valid) == int'(count_reg))
        else $error("entry count disagrees with valid cells");

    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOKUP) |-> $onehot0(c_match))
        else $error("key present in more than one cell");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == bblc_pkg::ST_HIT) |-> (rsp.evicted_count == '0))
        else $error("hit reported evictions");

endmodule

### dv/byte_budget_lru_cache_unit_checker.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_unit_checker: response checker for the LRU cache unit
// Watches the request, response and budget channels, keeps its own copy of
// the cache directory, and compares each response with the predicted one.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_unit_checker #(
    parameter int ENTRIES = bblc_pkg::ENTRIES_DFLT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           busy,
    input  bblc_pkg::req_t req,
    input  logic           done,
    input  bblc_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [31:0]    cfg_data,
    output int             fail_count,
    output int             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]                    budget;
    logic [bblc_pkg::KEY_BITS-1:0]  dir_key   [ENTRIES];
    logic [bblc_pkg::SIZE_BITS-1:0] dir_size  [ENTRIES];
    logic                           dir_valid [ENTRIES];
    int unsigned                    dir_rank  [ENTRIES];
    logic [63:0]                    used_bytes;
    bblc_pkg::rsp_t                 rsp_queue [$];

    assign pending = rsp_queue.size();

    function automatic bit drop_oldest();
        int victim;
        victim = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && (victim < 0 || dir_rank[i] > dir_rank[victim]))
                victim = i;
        if (victim < 0)
            return 0;
        dir_valid[victim] = 0;
        used_bytes -= dir_size[victim];
        return 1;
    endfunction

    function automatic void make_newest(int idx, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i] && i != idx && dir_rank[i] < limit)
                dir_rank[i]++;
        dir_rank[idx] = 0;
    endfunction

    function automatic bblc_pkg::rsp_t lookup_and_update(bblc_pkg::req_t r);
        bblc_pkg::rsp_t res;
        int hit;
        int slot;
        int live;
        int evicted;
        hit = -1;
        slot = -1;
        live = 0;
        evicted = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (hit < 0 && dir_valid[i] && dir_key[i] == r.key)
                hit = i;
        if (hit >= 0) begin
            make_newest(hit, dir_rank[hit]);
            res.status = bblc_pkg::ST_HIT;
        end else if (!r.present) begin
            res.status = bblc_pkg::ST_ABSENT;
        end else begin
            while (used_bytes + r.obj_size > budget && drop_oldest())
                evicted++;
            if (used_bytes + r.obj_size > budget) begin
                res.status = bblc_pkg::ST_PASSED;
            end else begin
                for (int i = 0; i < ENTRIES; i++)
                    if (dir_valid[i])
                        live++;
                if (live >= ENTRIES && drop_oldest())
                    evicted++;
                for (int i = 0; i < ENTRIES; i++)
                    if (slot < 0 && !dir_valid[i])
                        slot = i;
                dir_valid[slot] = 1;
                dir_key[slot]   = r.key;
                dir_size[slot]  = r.obj_size;
                used_bytes += r.obj_size;
                make_newest(slot, 32'hFFFF_FFFF);
                res.status = bblc_pkg::ST_STORED;
            end
        end
        res.evicted_count = evicted[bblc_pkg::EVICT_BITS-1:0];
        res.bytes_used    = used_bytes[bblc_pkg::USED_BITS-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        bblc_pkg::rsp_t want;
        if (!rst_n) begin
            budget     = bblc_pkg::BUDGET_RESET;
            used_bytes = 0;
            fail_count = 0;
            rsp_queue.delete();
            for (int i = 0; i < ENTRIES; i++)
            begin
                dir_valid[i] = 0;
                dir_rank[i]  = 0;
            end
        end else begin
            // A response may share its cycle with the next request, so the
            // response is checked against the queue before the new push.
            if (done) begin
                if (rsp_queue.size() == 0) begin
                    $display("%0t: unexpected response, expected none, actual %p", $time, rsp);
                    fail_count++;
                end else begin
                    want = rsp_queue.pop_front();
                    if (rsp.status !== want.status) begin
                        $display("%0t: status mismatch, expected %s, actual %0d",
                                 $time, want.status.name(), rsp.status);
                        fail_count++;
                    end
                    if (rsp.evicted_count !== want.evicted_count) begin
                        $display("%0t: evicted_count mismatch, expected %0d, actual %0d",
                                 $time, want.evicted_count, rsp.evicted_count);
                        fail_count++;
                    end
                    if (rsp.bytes_used !== want.bytes_used) begin
                        $display("%0t: bytes_used mismatch, expected %0d, actual %0d",
                                 $time, want.bytes_used, rsp.bytes_used);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                budget = cfg_data;
            if (start && !busy)
                rsp_queue.push_back(lookup_and_update(req));
        end
    end

endmodule

### dv/byte_budget_lru_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_unit_tb: testbench top of the LRU cache unit
// Drives directed and random requests over several byte budgets with random
// idle gaps; the checker predicts every response and counts mismatches.
// ----------------------------------------------------------------------------
module byte_budget_lru_cache_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bblc_pkg::req_t req;
    logic           done;
    bblc_pkg::rsp_t rsp;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [31:0]    cfg_data;
    int             fail_count;
    int             pending;
    bit             no_idle;
    logic [31:0]    key_pool [24];

    byte_budget_lru_cache_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    byte_budget_lru_cache_unit_checker i_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Issue one request; start stays high until it is taken and busy drops. The first wait
    // moves past the falling edge at which the previous request was dropped.
    task automatic send_request(logic [31:0] k, logic p, logic [23:0] sz);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < 36)
            @(negedge clk);
        start <= 1'b1;
        req   <= '{key: k, present: p, obj_size: sz};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        start <= 1'b0;
        req   <= '{key: $urandom, present: 1'($urandom_range(1)), obj_size: 24'($urandom)};
    endtask

    task automatic write_budget(logic [31:0] value);
        while (pending != 0)
            @(negedge clk);
        repeat (24) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int count, int max_size);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            no_idle = (n >= count / 2 && n < count / 2 + 60);
            if (pick < 80)
                send_request(key_pool[$urandom_range(23)], $urandom_range(7) != 0,
                             24'($urandom_range(max_size)));
            else if (pick < 95)
                send_request($urandom, 1'($urandom_range(1)),
                             24'($urandom_range(max_size)));
            else
                send_request($urandom, 1'($urandom_range(1)), 24'($urandom));
        end
        no_idle = 0;
    endtask

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        no_idle   = 0;
        for (int i = 0; i < 24; i++)
            key_pool[i] = $urandom;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty table, extremes, zero size, hits, absent, table full.
        send_request(32'h0, 1'b0, 24'h0);
        send_request(32'h0, 1'b1, 24'h0);
        send_request(32'hFFFF_FFFF, 1'b1, 24'd1000);
        send_request(32'h0, 1'b0, 24'hFF_FFFF);
        send_request(32'hFFFF_FFFF, 1'b0, 24'd5);
        send_request(32'h1234_5678, 1'b1, 24'hFF_FFFF);
        for (int i = 0; i < 17; i++)
            send_request(32'hA000_0000 + i, 1'b1, 24'd100);
        write_budget(32'd50);
        send_request(32'hA000_0010, 1'b1, 24'd7);
        send_request(32'hA000_0011, 1'b1, 24'd60);

        write_budget(32'd0);
        random_phase(100, 3);
        write_budget(32'hFFFF_FFFF);
        random_phase(400, 24'hFF_FFFF);
        write_budget(32'd65536);
        random_phase(500, 20000);
        write_budget(32'd4000);
        random_phase(400, 1500);
        write_budget(32'd300);
        random_phase(375, 120);

        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hdl/bblc_pkg.sv
hdl/bblc_cell.sv
hdl/byte_budget_lru_cache_unit.sv
dv/byte_budget_lru_cache_unit_checker.sv
dv/byte_budget_lru_cache_unit_tb.sv
